// ----- hdl/dvpp_pkg.sv -----
// dv isochronous packet pacer: shared types and constants
// no dependencies
package dvpp_pkg;

   localparam int unsigned RSP_FIFO_DEPTH = 4;

   localparam logic [8:0]  NTSC_SLOTS   = 9'd250;
   localparam logic [8:0]  PAL_SLOTS    = 9'd300;
   localparam logic [10:0] NTSC_THRESH  = 11'd1875;
   localparam logic [10:0] PAL_THRESH   = 11'd15;
   localparam logic [10:0] NTSC_INC     = 11'd127;
   localparam logic [10:0] PAL_INC      = 11'd1;
   localparam logic [31:0] NTSC_FMT     = 32'h8000_0000;
   localparam logic [31:0] PAL_FMT      = 32'h8080_0000;
   localparam logic [31:0] DATA_WORD0   = 32'h0078_0000;
   localparam logic [31:0] NO_STAMP     = 32'h0000_ffff;
   localparam logic [17:0] PAYLOAD_SIZE = 18'd480;
   localparam logic [12:0] CYCLES_WRAP  = 13'd8000;
   localparam logic [31:0] CYCLES_SUB   = 32'd8000 << 12;

   localparam logic [1:0]  PUSH_NONE = 2'd0;
   localparam logic [1:0]  PUSH_ONE  = 2'd1;
   localparam logic [1:0]  PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [31:0] cip_word0;
      logic [31:0] cip_word1;
      logic        has_payload;
      logic [17:0] payload_offset;
      logic        frame_end;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] n;
      rsp_type    entry0;
      rsp_type    entry1;
   } push_type;

endpackage

// ----- hdl/dvpp_core.sv -----
// dv pacer core: input register, config register, pacing state and header build
// depends on dvpp_pkg
module dvpp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [8:0]        req_slot_index,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_pal_mode,
   input  logic              room,
   output dvpp_pkg::push_type push
);
   import dvpp_pkg::*;

   logic        slot_valid_ff, slot_valid_in;
   logic [8:0]  slot_ff;
   logic        pal_ff;
   logic [10:0] acc_ff, acc_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [8:0]  fpc_ff, fpc_in;
   logic        fp_ff, fp_in;

   logic        take, accept, in_range, empty, fend, fp0, fp1;
   logic [8:0]  slots, fpc0, fpc1;
   logic [10:0] thr, inc, acc1;
   logic [31:0] fmt, stamp1, stamp2;
   rsp_type     r_empty, r_data;

   assign csr_ready = 1'b1;
   assign take      = slot_valid_ff && room;
   assign req_stall = slot_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      slots = pal_ff ? PAL_SLOTS : NTSC_SLOTS;
      thr   = pal_ff ? PAL_THRESH : NTSC_THRESH;
      inc   = pal_ff ? PAL_INC : NTSC_INC;
      fmt   = pal_ff ? PAL_FMT : NTSC_FMT;

      in_range = slot_ff < slots;
      fp0      = (slot_ff == 9'd0) ? 1'b1 : fp_ff;
      fpc0     = (slot_ff == 9'd0) ? 9'd0 : fpc_ff;
      empty    = acc_ff >= thr;
      acc1     = empty ? acc_ff - thr : acc_ff;
      fp1      = empty ? 1'b0 : fp0;
      fpc1     = fpc0 + 9'(empty) + 9'd1;
      fend     = slot_ff == slots - 9'd1;

      r_empty.cip_word0      = {24'd0, seq_ff};
      r_empty.cip_word1      = fmt | (fp0 ? {16'd0, stamp_ff[15:0]} : NO_STAMP);
      r_empty.has_payload    = 1'b0;
      r_empty.payload_offset = '0;
      r_empty.frame_end      = 1'b0;
      r_empty.last           = 1'b0;

      r_data.cip_word0       = DATA_WORD0 | {24'd0, seq_ff};
      r_data.cip_word1       = fmt | (fp1 ? {16'd0, stamp_ff[15:0]} : NO_STAMP);
      r_data.has_payload     = 1'b1;
      r_data.payload_offset  = 18'(slot_ff) * PAYLOAD_SIZE;
      r_data.frame_end       = fend;
      r_data.last            = 1'b1;

      // frame end: advance stamp by packets sent, wrap cycle count
      stamp1 = (stamp_ff | 32'd1) + {11'd0, fpc1, 12'd0};
      stamp2 = (stamp1[24:12] >= CYCLES_WRAP) ? stamp1 - CYCLES_SUB : stamp1;

      push.entry0 = empty ? r_empty : r_data;
      push.entry1 = r_data;
      if (!take || !in_range) begin
         push.n = PUSH_NONE;
      end else if (empty) begin
         push.n = PUSH_TWO;
      end else begin
         push.n = PUSH_ONE;
      end

      acc_in   = acc_ff;
      seq_in   = seq_ff;
      stamp_in = stamp_ff;
      fpc_in   = fpc_ff;
      fp_in    = fp_ff;
      if (take && in_range) begin
         acc_in = acc1 + inc;
         seq_in = seq_ff + 8'd1;
         if (fend) begin
            stamp_in = stamp2;
            fpc_in   = 9'd0;
            fp_in    = 1'b1;
         end else begin
            fpc_in = fpc1;
            fp_in  = 1'b0;
         end
      end

      if (accept) begin
         slot_valid_in = 1'b1;
      end else if (take) begin
         slot_valid_in = 1'b0;
      end else begin
         slot_valid_in = slot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         pal_ff        <= 1'b0;
         acc_ff        <= '0;
         seq_ff        <= '0;
         stamp_ff      <= '0;
         fpc_ff        <= '0;
         fp_ff         <= 1'b1;
      end else begin
         slot_valid_ff <= slot_valid_in;
         acc_ff        <= acc_in;
         seq_ff        <= seq_in;
         stamp_ff      <= stamp_in;
         fpc_ff        <= fpc_in;
         fp_ff         <= fp_in;
         if (csr_valid && csr_ready) begin
            pal_ff <= csr_pal_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= req_slot_index;
      end
   end

   a_cycles_wrapped: assert property (@(posedge clock) disable iff (reset)
      stamp_ff[24:12] < CYCLES_WRAP)
      else $error("cycle count left its range");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.n == PUSH_TWO) |-> (!push.entry0.has_payload && push.entry1.last))
      else $error("empty packet must precede data packet");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      accept |=> slot_valid_ff)
      else $error("accepted transaction lost from input register");

endmodule

// ----- hdl/dvpp_rsp_fifo.sv -----
// dv pacer result queue: takes up to two headers a cycle, gives one a cycle unless stalled
// depends on dvpp_pkg
module dvpp_rsp_fifo #(
   parameter int unsigned DEPTH = dvpp_pkg::RSP_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  dvpp_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dvpp_pkg::rsp_type  head
);
   import dvpp_pkg::*;

   localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rsp_type        entry_ff [DEPTH];
   logic [PW-1:0]  wp_ff, wp_in, wp1, rp_ff, rp_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = count_ff <= CW'(DEPTH - 2);
   assign head      = entry_ff[rp_ff];
   assign wp1       = bump(wp_ff);

   always_comb begin
      count_in = count_ff + CW'(push.n) - CW'(pop);
      rp_in    = pop ? bump(rp_ff) : rp_ff;
      case (push.n)
         PUSH_ONE: wp_in = wp1;
         PUSH_TWO: wp_in = bump(wp1);
         default:  wp_in = wp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != PUSH_NONE) begin
         entry_ff[wp_ff] <= push.entry0;
      end
      if (push.n == PUSH_TWO) begin
         entry_ff[wp1] <= push.entry1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.n != PUSH_NONE) |-> (count_ff <= CW'(DEPTH - 2)))
      else $error("push without room");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && push.n == PUSH_NONE) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("queue count did not follow pop");

endmodule

// ----- hdl/dv_isoch_packet_pacer.sv -----
// dv isochronous packet pacer: cip headers with blank-packet pacing
// path: a request is held in the core input register, then written to the result queue
// throughput: one slot a cycle for single-header slots while the queue has room;
// results drain one a cycle unless stalled; an empty-packet slot pushes two headers
// reset: synchronous, clears pacing state, pal_mode and the queue; no clearing pass
module dv_isoch_packet_pacer #(
   parameter int unsigned RSP_DEPTH = dvpp_pkg::RSP_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [8:0]  req_slot_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_pal_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cip_word0,
   output logic [31:0] rsp_cip_word1,
   output logic        rsp_has_payload,
   output logic [17:0] rsp_payload_offset,
   output logic        rsp_frame_end,
   output logic        rsp_last
);
   import dvpp_pkg::*;

   push_type push;
   rsp_type  head;
   logic     room;

   dvpp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_slot_index (req_slot_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_pal_mode   (csr_pal_mode),
      .room           (room),
      .push           (push)
   );

   dvpp_rsp_fifo #(.DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_cip_word0      = head.cip_word0;
   assign rsp_cip_word1      = head.cip_word1;
   assign rsp_has_payload    = head.has_payload;
   assign rsp_payload_offset = head.payload_offset;
   assign rsp_frame_end      = head.frame_end;
   assign rsp_last           = head.last;

endmodule
